>>> rtl/telnet_iac_stream_filter_unit_defines.svh
// Assertion macros for the Telnet IAC stream filter.
// Used by telnet_iac_stream_filter_unit.sv; expect clk and rst_n in scope.
`ifndef TELNET_IAC_STREAM_FILTER_UNIT_DEFINES_SVH
`define TELNET_IAC_STREAM_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TISF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TISF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/tisf_pkg.sv
// Package for the Telnet IAC stream filter: protocol byte codes, skip lengths
// and the parser mode type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tisf_pkg;

    localparam logic [7:0] BYTE_IAC = 8'd255;
    localparam logic [7:0] BYTE_SB  = 8'd250;
    localparam logic [7:0] OPT_NAWS = 8'd31;
    localparam logic [7:0] BYTE_NOP = 8'hf1;

    localparam int unsigned LEN_CMD     = 2;
    localparam int unsigned LEN_CMD_OPT = 3;
    localparam int unsigned LEN_NAWS    = 9;

    localparam int unsigned SKIP_W = 3;

    // Bytes still to drop once the command byte (or NAWS option) is seen.
    localparam logic [SKIP_W-1:0] SKIP_CMD_OPT = SKIP_W'(LEN_CMD_OPT - LEN_CMD);
    localparam logic [SKIP_W-1:0] SKIP_NAWS    = SKIP_W'(LEN_NAWS - LEN_CMD_OPT);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_IAC    = 2'd1,
        MODE_SB     = 2'd2,
        MODE_SKIP   = 2'd3
    } mode_t;

endpackage

`default_nettype wire

>>> rtl/telnet_iac_stream_filter_unit.sv
// Telnet IAC stream filter top level: input register, parser, result register.
// Depends on tisf_pkg and telnet_iac_stream_filter_unit_defines.svh.
//
//  channel | handshake          | payload                          | dir
//  --------+--------------------+----------------------------------+-----
//  input   | in_valid/in_ready  | data_byte[7:0], chunk_last       | in
//  result  | out_valid/out_ready| out_byte[7:0], byte_valid,       | out
//          |                    | chunk_end                        |
//
// One byte per clock unless a byte with a result waits on a stalled result
// register. Each result passes the input register, then the result register.
// Parser mode and skip count advance when the input register hands its byte on;
// dropped bytes retire without touching the result side, even under a stall.
// A new byte is accepted in the same cycle as the result register frees.
// Reset clears the parser to normal mode and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

`include "telnet_iac_stream_filter_unit_defines.svh"

module telnet_iac_stream_filter_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       chunk_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            chunk_end
);

    // Input register.
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    // Parser state.
    tisf_pkg::mode_t                 mode_reg, mode_next, mode_calc;
    logic [tisf_pkg::SKIP_W-1:0]     skip_reg, skip_next, skip_calc;

    // Result register.
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       chunk_end_reg;

    logic       emit;
    logic       has_result;
    logic       out_load;
    logic       s1_fire;

    // Handshake: a byte leaves the input register when it makes no result,
    // or when the result register is empty or being drained this cycle.
    assign has_result = emit | s1_last_reg;
    assign out_load   = ~out_valid_reg | out_ready;
    assign s1_fire    = s1_valid_reg & (~has_result | out_load);
    assign in_ready   = ~s1_valid_reg | s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= chunk_last;
        end
    end

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tisf_pkg::MODE_NORMAL;
            skip_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            skip_reg <= skip_next;
        end
    end

    // Next parser state and emit decision for the byte in the input register.
    always_comb
    begin
        mode_calc = mode_reg;
        skip_calc = skip_reg;
        emit      = 1'b0;
        case (mode_reg)
            tisf_pkg::MODE_NORMAL:
            begin
                if (s1_byte_reg != tisf_pkg::BYTE_IAC)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    mode_calc = tisf_pkg::MODE_IAC;
                end
            end
            tisf_pkg::MODE_IAC:
            begin
                if (s1_byte_reg == tisf_pkg::BYTE_NOP || s1_last_reg)
                begin
                    mode_calc = tisf_pkg::MODE_NORMAL;
                end
                else if (s1_byte_reg == tisf_pkg::BYTE_IAC)
                begin
                    // escaped 0xFF: the byte itself is the data
                    emit      = 1'b1;
                    mode_calc = tisf_pkg::MODE_NORMAL;
                end
                else if (s1_byte_reg == tisf_pkg::BYTE_SB)
                begin
                    mode_calc = tisf_pkg::MODE_SB;
                end
                else
                begin
                    mode_calc = tisf_pkg::MODE_SKIP;
                    skip_calc = tisf_pkg::SKIP_CMD_OPT;
                end
            end
            tisf_pkg::MODE_SB:
            begin
                if (s1_byte_reg == tisf_pkg::OPT_NAWS)
                begin
                    mode_calc = tisf_pkg::MODE_SKIP;
                    skip_calc = tisf_pkg::SKIP_NAWS;
                end
                else
                begin
                    mode_calc = tisf_pkg::MODE_NORMAL;
                end
            end
            tisf_pkg::MODE_SKIP:
            begin
                // count at one or zero: this is the final dropped byte
                if (skip_reg <= tisf_pkg::SKIP_W'(1))
                begin
                    skip_calc = '0;
                    mode_calc = tisf_pkg::MODE_NORMAL;
                end
                else
                begin
                    skip_calc = skip_reg - tisf_pkg::SKIP_W'(1);
                end
            end
            default:
            begin
                mode_calc = tisf_pkg::MODE_NORMAL;
                skip_calc = '0;
            end
        endcase

        // chunk end always returns the parser to normal
        if (s1_last_reg)
        begin
            mode_calc = tisf_pkg::MODE_NORMAL;
            skip_calc = '0;
        end

        mode_next = s1_fire ? mode_calc : mode_reg;
        skip_next = s1_fire ? skip_calc : skip_reg;
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && has_result)
        begin
            out_byte_reg   <= emit ? s1_byte_reg : 8'd0;
            byte_valid_reg <= emit;
            chunk_end_reg  <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign chunk_end  = chunk_end_reg;

    // A result without a data byte only comes from a chunk end.
    `TISF_ASSERT_NOW(a_empty_result_is_chunk_end, out_valid_reg && !byte_valid_reg,
        chunk_end_reg, "result without data byte lacks chunk end")

    // Empty result carries a zero byte.
    `TISF_ASSERT_NOW(a_empty_result_zero_byte, out_valid_reg && !byte_valid_reg,
        out_byte_reg == 8'd0, "empty result has nonzero byte")

    // Skip count is nonzero exactly while skipping.
    `TISF_ASSERT_NOW(a_skip_count_matches_mode, 1'b1,
        (mode_reg == tisf_pkg::MODE_SKIP) == (skip_reg != '0),
        "skip count inconsistent with parser mode")

    // Parser is back in normal mode after a chunk's last byte retires.
    `TISF_ASSERT_NEXT(a_chunk_end_resets_parser, s1_fire && s1_last_reg,
        mode_reg == tisf_pkg::MODE_NORMAL && skip_reg == '0,
        "parser not reset at chunk end")

endmodule

`default_nettype wire
